// ===== sv/tsi_pkg.sv =====
`default_nettype none

package tsi_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;

    // Serial divider, one quotient bit per cycle
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BEFORE = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_BS_RD,
        S_BS_CMP,
        S_LS_RD,
        S_LS_CMP,
        S_K2_RD,
        S_K2_GET,
        S_K1_RD,
        S_K1_GET,
        S_CHK,
        S_MUL,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    // Datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_START,
        OP_BS_RD,
        OP_BS_STEP,
        OP_BS_END,
        OP_LS_RD,
        OP_LS_DEC,
        OP_K2_RD,
        OP_K2_GET,
        OP_K1_RD,
        OP_K1_GET,
        OP_CHK,
        OP_MUL,
        OP_DIV,
        OP_FIN,
        OP_OUT
    } t_dp_op;

    // Datapath status back to the controller
    typedef struct packed {
        logic [1:0] mode;      // mode of the item in hand
        logic       cnt_zero;  // table empty
        logic       sorted;    // times loaded in non-decreasing order
        logic       lo_lt_hi;  // binary search window not yet closed
        logic       k2_zero;   // linear scan at the bottom entry
        logic       rd_gt_q;   // time read back is later than the query
        logic       pre_first; // query precedes the first sample
        logic       same;      // exact hit or duplicate neighbours
        logic       div_last;  // final divider step
        logic       out_free;  // output register can take a result
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== sv/tsi_if.sv =====
`default_nettype none

// Request channel: one item per handshake
interface tsi_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [31:0]        sample_time;
    logic signed [31:0] sample_price;
    logic [31:0]        query_time;

    modport source (output valid, output mode, output sample_time,
                    output sample_price, output query_time, input ready);
    modport sink   (input valid, input mode, input sample_time,
                    input sample_price, input query_time, output ready);
endinterface

// Result channel
interface tsi_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] price;

    modport source (output valid, output status, output price, input ready);
    modport sink   (input valid, input status, input price, output ready);
endinterface

`default_nettype wire

// ===== sv/tsi_ram.sv =====
`default_nettype none

// Simple dual-port RAM, registered read
module tsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/tsi_ctrl.sv =====
`default_nettype none

// Sequencer: one item at a time
module tsi_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire tsi_pkg::t_dp_stat i_stat,
    output logic                   o_in_ready,
    output tsi_pkg::t_dp_op        o_op
);

    tsi_pkg::t_state r_state;
    tsi_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath command
    always_comb begin
        n_state    = r_state;
        o_op       = tsi_pkg::OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            tsi_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = tsi_pkg::OP_CAPTURE;
                    n_state = tsi_pkg::S_START;
                end
            end
            tsi_pkg::S_START: begin
                o_op = tsi_pkg::OP_START;
                if (i_stat.mode == tsi_pkg::MODE_QUERY && !i_stat.cnt_zero) begin
                    n_state = i_stat.sorted ? tsi_pkg::S_BS_RD : tsi_pkg::S_LS_RD;
                end else begin
                    n_state = tsi_pkg::S_DONE;
                end
            end
            // Binary search over a sorted table
            tsi_pkg::S_BS_RD: begin
                if (i_stat.lo_lt_hi) begin
                    o_op    = tsi_pkg::OP_BS_RD;
                    n_state = tsi_pkg::S_BS_CMP;
                end else begin
                    o_op    = tsi_pkg::OP_BS_END;
                    n_state = tsi_pkg::S_K2_RD;
                end
            end
            tsi_pkg::S_BS_CMP: begin
                o_op    = tsi_pkg::OP_BS_STEP;
                n_state = tsi_pkg::S_BS_RD;
            end
            // Downward scan when loads came out of order
            tsi_pkg::S_LS_RD: begin
                if (i_stat.k2_zero) begin
                    n_state = tsi_pkg::S_K2_RD;
                end else begin
                    o_op    = tsi_pkg::OP_LS_RD;
                    n_state = tsi_pkg::S_LS_CMP;
                end
            end
            tsi_pkg::S_LS_CMP: begin
                if (i_stat.rd_gt_q) begin
                    o_op    = tsi_pkg::OP_LS_DEC;
                    n_state = tsi_pkg::S_LS_RD;
                end else begin
                    n_state = tsi_pkg::S_K2_RD;
                end
            end
            // Fetch both neighbours
            tsi_pkg::S_K2_RD: begin
                o_op    = tsi_pkg::OP_K2_RD;
                n_state = tsi_pkg::S_K2_GET;
            end
            tsi_pkg::S_K2_GET: begin
                o_op    = tsi_pkg::OP_K2_GET;
                n_state = i_stat.pre_first ? tsi_pkg::S_DONE : tsi_pkg::S_K1_RD;
            end
            tsi_pkg::S_K1_RD: begin
                o_op    = tsi_pkg::OP_K1_RD;
                n_state = tsi_pkg::S_K1_GET;
            end
            tsi_pkg::S_K1_GET: begin
                o_op    = tsi_pkg::OP_K1_GET;
                n_state = tsi_pkg::S_CHK;
            end
            tsi_pkg::S_CHK: begin
                o_op    = tsi_pkg::OP_CHK;
                n_state = i_stat.same ? tsi_pkg::S_DONE : tsi_pkg::S_MUL;
            end
            // Interpolation: multiply, then serial divide
            tsi_pkg::S_MUL: begin
                o_op    = tsi_pkg::OP_MUL;
                n_state = tsi_pkg::S_DIV;
            end
            tsi_pkg::S_DIV: begin
                o_op = tsi_pkg::OP_DIV;
                if (i_stat.div_last) begin
                    n_state = tsi_pkg::S_FIN;
                end
            end
            tsi_pkg::S_FIN: begin
                o_op    = tsi_pkg::OP_FIN;
                n_state = tsi_pkg::S_DONE;
            end
            // Hand the result to the output register
            tsi_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_op    = tsi_pkg::OP_OUT;
                    n_state = tsi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tsi_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/tsi_dp.sv =====
`default_nettype none

// Sample tables, search registers, multiplier and serial divider
module tsi_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tsi_pkg::t_dp_op   i_op,
    input  wire logic [1:0]        i_mode,
    input  wire logic [31:0]       i_sample_time,
    input  wire logic [31:0]       i_sample_price,
    input  wire logic [31:0]       i_query_time,
    input  wire logic              i_out_ready,
    output tsi_pkg::t_dp_stat      o_stat,
    output logic                   o_out_valid,
    output logic [1:0]             o_out_status,
    output logic [31:0]            o_out_price
);

    localparam int AW = tsi_pkg::ADDR_W;
    localparam int CW = tsi_pkg::CNT_W;
    localparam int DW = tsi_pkg::DATA_W;
    localparam int QW = tsi_pkg::DIV_CNT_W;

    // Item in hand
    logic [1:0]    r_mode, n_mode;
    logic [DW-1:0] r_stime, n_stime;
    logic [DW-1:0] r_sprice, n_sprice;
    logic [DW-1:0] r_q, n_q;

    // Table bookkeeping
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_sorted, n_sorted;
    logic [DW-1:0] r_last_time, n_last_time;

    // Search
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [AW-1:0] r_k2, n_k2;
    logic [AW-1:0] r_k1, n_k1;

    // Neighbours
    logic [DW-1:0] r_t1, n_t1;
    logic [DW-1:0] r_t2, n_t2;
    logic [DW-1:0] r_p1, n_p1;
    logic [DW-1:0] r_p2, n_p2;

    // Interpolation
    logic          r_neg, n_neg;
    logic [DW-1:0] r_mag, n_mag;
    logic [DW-1:0] r_num, n_num;
    logic [DW-1:0] r_den, n_den;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [QW-1:0] r_div_cnt, n_div_cnt;

    // Result and output register
    logic [1:0]    r_res_status, n_res_status;
    logic [DW-1:0] r_res_price, n_res_price;
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_status, n_out_status;
    logic [DW-1:0] r_out_price, n_out_price;

    // Memory ports
    logic          mem_we;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] rd_time;
    logic [DW-1:0] rd_price;

    // Helpers
    logic          full;
    logic [CW-1:0] cnt_m1;
    logic [CW:0]   lo_hi_sum;
    logic [AW-1:0] mid;
    logic [AW-1:0] k2_m1;
    logic          rd_gt_q;
    logic          same;
    logic [DW:0]   dp;
    logic [DW:0]   dp_neg;
    logic [2*DW-1:0] prod;
    logic [DW:0]   div_sh;
    logic [DW:0]   div_diff;
    logic          div_ge;

    assign full      = (r_cnt == CW'(tsi_pkg::TABLE_DEPTH));
    assign cnt_m1    = r_cnt - CW'(1);
    assign lo_hi_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = lo_hi_sum[AW:1];
    assign k2_m1     = r_k2 - AW'(1);
    assign rd_gt_q   = (rd_time > r_q);
    assign same      = (r_t1 == r_t2) || (r_q == r_t1);
    assign dp        = {r_p2[DW-1], r_p2} - {r_p1[DW-1], r_p1};
    assign dp_neg    = -dp;
    assign prod      = r_mag * r_num;
    assign div_sh    = {r_rem, r_quo[DW-1]};
    assign div_diff  = div_sh - {1'b0, r_den};
    assign div_ge    = (div_sh >= {1'b0, r_den});

    // Write on a load into a table with room; shared read address
    assign mem_we = (i_op == tsi_pkg::OP_START) && (r_mode == tsi_pkg::MODE_LOAD) && !full;

    always_comb begin
        unique case (i_op)
            tsi_pkg::OP_BS_RD: mem_raddr = mid;
            tsi_pkg::OP_LS_RD: mem_raddr = k2_m1;
            tsi_pkg::OP_K1_RD: mem_raddr = r_k1;
            default:           mem_raddr = r_k2;
        endcase
    end

    tsi_ram #(.WIDTH(DW), .DEPTH(tsi_pkg::TABLE_DEPTH)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (r_stime),
        .i_raddr (mem_raddr),
        .o_rdata (rd_time)
    );

    tsi_ram #(.WIDTH(DW), .DEPTH(tsi_pkg::TABLE_DEPTH)) u_price_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (r_sprice),
        .i_raddr (mem_raddr),
        .o_rdata (rd_price)
    );

    // Next values per command
    always_comb begin
        n_mode       = r_mode;
        n_stime      = r_stime;
        n_sprice     = r_sprice;
        n_q          = r_q;
        n_cnt        = r_cnt;
        n_sorted     = r_sorted;
        n_last_time  = r_last_time;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_k2         = r_k2;
        n_k1         = r_k1;
        n_t1         = r_t1;
        n_t2         = r_t2;
        n_p1         = r_p1;
        n_p2         = r_p2;
        n_neg        = r_neg;
        n_mag        = r_mag;
        n_num        = r_num;
        n_den        = r_den;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_div_cnt    = r_div_cnt;
        n_res_status = r_res_status;
        n_res_price  = r_res_price;
        n_out_status = r_out_status;
        n_out_price  = r_out_price;
        n_out_valid  = r_out_valid && !i_out_ready;

        unique case (i_op)
            tsi_pkg::OP_CAPTURE: begin
                n_mode   = i_mode;
                n_stime  = i_sample_time;
                n_sprice = i_sample_price;
                n_q      = i_query_time;
            end
            tsi_pkg::OP_START: begin
                n_res_status = tsi_pkg::ST_OK;
                n_res_price  = '0;
                n_lo         = '0;
                n_hi         = r_cnt;
                n_k2         = cnt_m1[AW-1:0];
                unique case (r_mode)
                    tsi_pkg::MODE_LOAD: begin
                        if (full) begin
                            n_res_status = tsi_pkg::ST_FULL;
                        end else begin
                            n_cnt       = r_cnt + CW'(1);
                            n_last_time = r_stime;
                            if (r_cnt != '0 && r_stime < r_last_time) begin
                                n_sorted = 1'b0;
                            end
                        end
                    end
                    tsi_pkg::MODE_QUERY: begin
                        if (r_cnt == '0) begin
                            n_res_status = tsi_pkg::ST_EMPTY;
                        end
                    end
                    tsi_pkg::MODE_CLEAR: begin
                        n_cnt    = '0;
                        n_sorted = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            // Narrow the window on the count of times not after the query
            tsi_pkg::OP_BS_STEP: begin
                if (rd_gt_q) begin
                    n_hi = CW'(mid);
                end else begin
                    n_lo = CW'(mid) + CW'(1);
                end
            end
            tsi_pkg::OP_BS_END: begin
                n_k2 = (r_lo == r_cnt) ? cnt_m1[AW-1:0] : r_lo[AW-1:0];
            end
            tsi_pkg::OP_LS_DEC: begin
                n_k2 = k2_m1;
            end
            // Upper neighbour back; choose the lower one
            tsi_pkg::OP_K2_GET: begin
                n_t2 = rd_time;
                n_p2 = rd_price;
                if (r_k2 == '0 || !rd_gt_q) begin
                    n_k1 = r_k2;
                end else begin
                    n_k1 = k2_m1;
                end
                if (r_k2 == '0 && rd_gt_q) begin
                    n_res_status = tsi_pkg::ST_BEFORE;
                end
            end
            tsi_pkg::OP_K1_GET: begin
                n_t1 = rd_time;
                n_p1 = rd_price;
            end
            // Exact hit, or set up the span for interpolation
            tsi_pkg::OP_CHK: begin
                if (same) begin
                    n_res_price = r_p1;
                end
                n_neg = dp[DW];
                n_mag = dp[DW] ? dp_neg[DW-1:0] : dp[DW-1:0];
                n_num = r_q - r_t1;
                n_den = r_t2 - r_t1;
            end
            // Product high half is below the divisor, so 32 steps suffice
            tsi_pkg::OP_MUL: begin
                n_rem     = prod[2*DW-1:DW];
                n_quo     = prod[DW-1:0];
                n_div_cnt = '0;
            end
            tsi_pkg::OP_DIV: begin
                n_rem     = div_ge ? div_diff[DW-1:0] : div_sh[DW-1:0];
                n_quo     = {r_quo[DW-2:0], div_ge};
                n_div_cnt = r_div_cnt + QW'(1);
            end
            tsi_pkg::OP_FIN: begin
                n_res_price = r_neg ? (r_p1 - r_quo) : (r_p1 + r_quo);
            end
            tsi_pkg::OP_OUT: begin
                n_out_valid  = 1'b1;
                n_out_status = r_res_status;
                n_out_price  = r_res_price;
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_sorted    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_sorted    <= n_sorted;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_stime      <= n_stime;
        r_sprice     <= n_sprice;
        r_q          <= n_q;
        r_last_time  <= n_last_time;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_k2         <= n_k2;
        r_k1         <= n_k1;
        r_t1         <= n_t1;
        r_t2         <= n_t2;
        r_p1         <= n_p1;
        r_p2         <= n_p2;
        r_neg        <= n_neg;
        r_mag        <= n_mag;
        r_num        <= n_num;
        r_den        <= n_den;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_div_cnt    <= n_div_cnt;
        r_res_status <= n_res_status;
        r_res_price  <= n_res_price;
        r_out_status <= n_out_status;
        r_out_price  <= n_out_price;
    end

    // Status to the controller
    always_comb begin
        o_stat.mode      = r_mode;
        o_stat.cnt_zero  = (r_cnt == '0);
        o_stat.sorted    = r_sorted;
        o_stat.lo_lt_hi  = (r_lo < r_hi);
        o_stat.k2_zero   = (r_k2 == '0);
        o_stat.rd_gt_q   = rd_gt_q;
        o_stat.pre_first = (r_k2 == '0) && rd_gt_q;
        o_stat.same      = same;
        o_stat.div_last  = (r_div_cnt == QW'(tsi_pkg::DIV_STEPS - 1));
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_price  = r_out_price;

endmodule

`default_nettype wire

// ===== sv/time_series_interpolator.sv =====
`default_nettype none

// Channel  Dir  Fields                                             Accepted when
// i_req    in   mode, sample_time, sample_price, query_time        valid && ready
// o_rsp    out  status, price                                      valid && ready
//
// Items are handled one at a time. Load, clear and unused modes skip the search.
// An interpolated query on a table loaded in time order runs a binary search, each
// probe a registered read of the single-read-port tables, then a serial divider.
// After an out-of-order load, queries scan downward entry by entry until the table
// is cleared. Reset empties the table; the stores keep data.
// A waiting result sits in the output register while the next item is taken.
module time_series_interpolator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tsi_in_if.sink     i_req,
    tsi_out_if.source  o_rsp
);

    tsi_pkg::t_dp_op   op;
    tsi_pkg::t_dp_stat stat;
    logic              in_ready;
    logic              out_valid;
    logic [1:0]        out_status;
    logic [31:0]       out_price;

    tsi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_op       (op)
    );

    tsi_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_mode         (i_req.mode),
        .i_sample_time  (i_req.sample_time),
        .i_sample_price (i_req.sample_price),
        .i_query_time   (i_req.query_time),
        .i_out_ready    (o_rsp.ready),
        .o_stat         (stat),
        .o_out_valid    (out_valid),
        .o_out_status   (out_status),
        .o_out_price    (out_price)
    );

    assign i_req.ready  = in_ready;
    assign o_rsp.valid  = out_valid;
    assign o_rsp.status = out_status;
    assign o_rsp.price  = out_price;

endmodule

`default_nettype wire

// ===== tb/time_series_interpolator_tb.sv =====
`default_nettype none

module time_series_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int DRAIN_CYCLES = 200;

    // Mode value the block ignores
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        sample_time;
        logic signed [31:0] sample_price;
        logic [31:0]        query_time;
    } t_req_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] price;
    } t_rsp_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsi_in_if  req_if ();
    tsi_out_if rsp_if ();

    time_series_interpolator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the sample table
    logic [31:0]        tbl_time  [tsi_pkg::TABLE_DEPTH];
    logic signed [31:0] tbl_price [tsi_pkg::TABLE_DEPTH];
    int unsigned        n_samples = 0;

    t_req_item   req_backlog [$];  // items waiting to be driven
    t_rsp_item   due_rsp     [$];  // results owed by the block, oldest first
    logic [31:0] plan_times  [$];  // table times as the stimulus will leave them

    int n_accepted = 0;
    int fail_cnt   = 0;
    int cycle_cnt  = 0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one item to the shadow table and return the result it owes
    function automatic t_rsp_item apply_item(t_req_item it);
        t_rsp_item          r;
        int unsigned        k1, k2;
        logic [31:0]        q, t1, t2, dq, dt;
        longint             p1, p2, dp, res;
        longint unsigned    mag, quot;
        r.status = tsi_pkg::ST_OK;
        r.price  = '0;
        case (it.mode)
            tsi_pkg::MODE_LOAD: begin
                if (n_samples >= tsi_pkg::TABLE_DEPTH) begin
                    r.status = tsi_pkg::ST_FULL;
                end else begin
                    tbl_time[n_samples]  = it.sample_time;
                    tbl_price[n_samples] = it.sample_price;
                    n_samples++;
                end
            end
            tsi_pkg::MODE_CLEAR: n_samples = 0;
            tsi_pkg::MODE_QUERY: begin
                q = it.query_time;
                if (n_samples == 0) begin
                    r.status = tsi_pkg::ST_EMPTY;
                end else begin
                    // walk down to the upper neighbour
                    k2 = n_samples - 1;
                    while (k2 > 0 && tbl_time[k2 - 1] > q)
                        k2--;
                    if (k2 == 0 && tbl_time[0] > q) begin
                        r.status = tsi_pkg::ST_BEFORE;
                    end else begin
                        k1 = (k2 == 0 || tbl_time[k2] <= q) ? k2 : k2 - 1;
                        t1 = tbl_time[k1];
                        t2 = tbl_time[k2];
                        if (t1 == t2 || q == t1) begin
                            r.price = tbl_price[k1];
                        end else begin
                            // t1 < q < t2: exact interpolation, quotient toward zero
                            p1   = longint'(tbl_price[k1]);
                            p2   = longint'(tbl_price[k2]);
                            dp   = p2 - p1;
                            mag  = (dp < 0) ? -dp : dp;
                            dq   = q - t1;
                            dt   = t2 - t1;
                            quot = (mag * {32'd0, dq}) / {32'd0, dt};
                            res  = (dp < 0) ? p1 - longint'(quot) : p1 + longint'(quot);
                            r.price = res[31:0];
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Idle share per phase: none, sender, receiver, both
    function automatic int unsigned src_idle_pct(int n);
        case ((n / 97) % 4)
            1:       return 60;
            3:       return 15;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned snk_stall_pct(int n);
        case ((n / 97) % 4)
            2:       return 60;
            3:       return 15;
            default: return 0;
        endcase
    endfunction

    // Stimulus helpers
    task automatic queue_raw(logic [1:0] mode, logic [31:0] st, logic [31:0] sp,
                             logic [31:0] qt);
        t_req_item it;
        it.mode         = mode;
        it.sample_time  = st;
        it.sample_price = sp;
        it.query_time   = qt;
        req_backlog.push_back(it);
    endtask

    task automatic queue_load(logic [31:0] t, logic [31:0] p);
        queue_raw(tsi_pkg::MODE_LOAD, t, p, $urandom);
        if (plan_times.size() < tsi_pkg::TABLE_DEPTH)
            plan_times.push_back(t);
    endtask

    task automatic queue_query(logic [31:0] q);
        queue_raw(tsi_pkg::MODE_QUERY, $urandom, $urandom, q);
    endtask

    task automatic queue_clear();
        queue_raw(tsi_pkg::MODE_CLEAR, $urandom, $urandom, $urandom);
        plan_times.delete();
    endtask

    function automatic logic [31:0] rand_price();
        if ($urandom_range(1))
            return $urandom;
        return $urandom_range(200000) - 100000;
    endfunction

    // Query time aimed at the table: exact hit, gap, before, after or anywhere
    function automatic logic [31:0] pick_query_time();
        int          n;
        int unsigned i;
        logic [31:0] lo, hi, sw;
        n = plan_times.size();
        if (n == 0)
            return $urandom;
        case ($urandom_range(5))
            0: return plan_times[$urandom_range(n - 1)];
            1, 2: begin
                i  = $urandom_range(n - 1);
                lo = plan_times[i];
                hi = (i + 1 < n) ? plan_times[i + 1] : 32'hFFFF_FFFF;
                if (lo > hi) begin
                    sw = lo;
                    lo = hi;
                    hi = sw;
                end
                if (hi - lo > 1)
                    return $urandom_range(hi - 1, lo + 1);
                return lo;
            end
            3: begin
                lo = plan_times[0];
                if (lo == 0)
                    return 32'd0;
                return $urandom_range(lo - 1, 0);
            end
            4: return $urandom_range(32'hFFFF_FFFF, plan_times[n - 1]);
            default: begin
                case ($urandom_range(3))
                    0:       return 32'd0;
                    1:       return 32'hFFFF_FFFF;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // Driver: present the next item once the current one is taken
    always @(posedge i_clk) begin : drive_proc
        t_req_item it;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                it.mode         = req_if.mode;
                it.sample_time  = req_if.sample_time;
                it.sample_price = req_if.sample_price;
                it.query_time   = req_if.query_time;
                due_rsp.push_back(apply_item(it));
                n_accepted <= n_accepted + 1;
            end
            if (!req_if.valid || req_if.ready) begin
                if (req_backlog.size() > 0 && $urandom_range(99) >= src_idle_pct(n_accepted)) begin
                    it = req_backlog.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.mode         <= it.mode;
                    req_if.sample_time  <= it.sample_time;
                    req_if.sample_price <= it.sample_price;
                    req_if.query_time   <= it.query_time;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure, compare each result with the oldest owed
    always @(posedge i_clk) begin : check_proc
        t_rsp_item exp_rsp;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (due_rsp.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d price %0d",
                             $time, rsp_if.status, rsp_if.price);
                    fail_cnt++;
                end else begin
                    exp_rsp = due_rsp.pop_front();
                    if (rsp_if.status !== exp_rsp.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, exp_rsp.status, rsp_if.status);
                        fail_cnt++;
                    end
                    if (rsp_if.price !== exp_rsp.price) begin
                        $display("%0t: price mismatch, expected %0d, actual %0d",
                                 $time, exp_rsp.price, rsp_if.price);
                        fail_cnt++;
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct(n_accepted));
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        logic [63:0] t;
        int unsigned step_max;
        int          n, m, i, target, kind;
        logic [31:0] a;
        logic [1:0]  md;

        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.mode         = tsi_pkg::MODE_LOAD;
        req_if.sample_time  = '0;
        req_if.sample_price = '0;
        req_if.query_time   = '0;
        rsp_if.ready        = 1'b0;

        // Directed: empty table, unused mode, price and time extremes,
        // duplicate times, out-of-order load
        queue_query(32'd0);
        queue_raw(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_load(32'd100, 32'h7FFF_FFFF);
        queue_load(32'd200, 32'h8000_0000);
        queue_load(32'd200, 32'd5);
        queue_load(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_query(32'd0);
        queue_query(32'd100);
        queue_query(32'd150);
        queue_query(32'd199);
        queue_query(32'd200);
        queue_query(32'hFFFF_FFFE);
        queue_query(32'hFFFF_FFFF);
        queue_clear();
        queue_query(32'd7);
        queue_load(32'd0, 32'h8000_0000);
        queue_load(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        queue_query(32'h8000_0000);
        queue_query(32'd0);
        queue_load(32'd5, 32'd1);
        queue_query(32'd3);
        queue_query(32'hFFFF_FFFF);
        queue_raw(MODE_UNUSED, 32'd0, 32'd0, 32'd0);
        queue_clear();

        // Random sessions: mostly ordered tables with aimed queries
        target = req_backlog.size() + RANDOM_ITEMS;
        while (req_backlog.size() < target) begin
            kind = $urandom_range(19);
            if ($urandom_range(7) != 0)
                queue_clear();
            if (kind < 14) begin
                n = ($urandom_range(24) == 0) ? $urandom_range(300, 100) : $urandom_range(24, 1);
                case ($urandom_range(3))
                    0:       step_max = 1;
                    1:       step_max = 200;
                    2:       step_max = 1 << 16;
                    default: step_max = 1 << 26;
                endcase
                case ($urandom_range(2))
                    0:       t = 64'd0;
                    1:       t = {32'd0, $urandom};
                    default: t = 64'hFFFF_FFFF - $urandom_range(5000);
                endcase
                for (i = 0; i < n; i++) begin
                    queue_load((t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0], rand_price());
                    // occasional zero step gives duplicate times
                    if ($urandom_range(7) != 0)
                        t += $urandom_range(step_max, 1);
                end
                m = $urandom_range(12, 3);
                for (i = 0; i < m; i++)
                    queue_query(pick_query_time());
            end else if (kind < 17) begin
                // unordered table, kept small since lookups scan it
                n = $urandom_range(16, 2);
                for (i = 0; i < n; i++) begin
                    if (plan_times.size() > 0 && $urandom_range(3) == 0)
                        a = plan_times[$urandom_range(plan_times.size() - 1)];
                    else
                        a = $urandom;
                    queue_load(a, rand_price());
                end
                m = $urandom_range(10, 4);
                for (i = 0; i < m; i++)
                    queue_query(pick_query_time());
            end else begin
                // noise: any mode, any field
                m = $urandom_range(12, 4);
                for (i = 0; i < m; i++) begin
                    md = $urandom_range(3);
                    case (md)
                        tsi_pkg::MODE_LOAD:  queue_load($urandom, $urandom);
                        tsi_pkg::MODE_QUERY: queue_query($urandom);
                        tsi_pkg::MODE_CLEAR: queue_clear();
                        default:             queue_raw(MODE_UNUSED, $urandom, $urandom,
                                                       $urandom);
                    endcase
                end
            end
        end

        // Fill the table, overflow it, query the deepest search, then clear
        queue_clear();
        for (i = 0; i < tsi_pkg::TABLE_DEPTH; i++)
            queue_load(i * 1000 + 500, rand_price());
        for (i = 0; i < 3; i++)
            queue_load($urandom, $urandom);
        queue_query(32'd0);
        queue_query(32'd499);
        queue_query(32'd500);
        queue_query((tsi_pkg::TABLE_DEPTH - 1) * 1000 + 500);
        queue_query(32'hFFFF_FFFF);
        for (i = 0; i < 4; i++)
            queue_query($urandom_range(tsi_pkg::TABLE_DEPTH - 2) * 1000 + 500
                        + $urandom_range(999, 1));
        queue_clear();
        queue_query($urandom);
        queue_load(32'd10, 32'd20);
        queue_query(32'd11);

        // Reset, then let the driver and monitor run
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_if.valid || due_rsp.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
